>>> src/msa_pkg.sv
// msa_pkg: types and constants shared by the multitouch slot accumulator
// holds transaction structs, slot entry layout, operation and event codes
// no dependencies
package msa_pkg;

    // operation codes of an input transaction
    typedef enum logic [1:0] {
        OP_EVENT     = 2'd0,
        OP_FRAME_END = 2'd1,
        OP_RESET     = 2'd2,
        OP_READ      = 2'd3
    } op_t;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_MODIFY
    } state_t;

    // evdev event types
    localparam logic [4:0] EVT_SYN = 5'd0;
    localparam logic [4:0] EVT_ABS = 5'd3;

    // evdev event codes
    localparam logic [9:0] CODE_MT_REPORT = 10'h002;
    localparam logic [9:0] CODE_SLOT      = 10'h02f;
    localparam logic [9:0] CODE_TMAJOR    = 10'h030;
    localparam logic [9:0] CODE_TMINOR    = 10'h031;
    localparam logic [9:0] CODE_WMAJOR    = 10'h032;
    localparam logic [9:0] CODE_WMINOR    = 10'h033;
    localparam logic [9:0] CODE_ORIENT    = 10'h034;
    localparam logic [9:0] CODE_X         = 10'h035;
    localparam logic [9:0] CODE_Y         = 10'h036;
    localparam logic [9:0] CODE_TRACK     = 10'h039;
    localparam logic [9:0] CODE_PRESS     = 10'h03a;
    localparam logic [9:0] CODE_DIST      = 10'h03b;

    // slot flag bits
    localparam int FLAG_INUSE  = 0;
    localparam int FLAG_TMINOR = 1;
    localparam int FLAG_WMINOR = 2;

    // configuration register indexes
    localparam logic REG_SLOT_COUNT = 1'b0;
    localparam logic REG_PROTOCOL   = 1'b1;

    // input transaction
    typedef struct packed {
        op_t                operation;
        logic [4:0]         event_type;
        logic [9:0]         event_code;
        logic signed [31:0] event_value;
        logic signed [31:0] initial_slot;
        logic [3:0]         read_index;
    } item_t;

    // one slot as stored in the slot memory
    typedef struct packed {
        logic [2:0]         slot_flags;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] touch_major;
        logic signed [31:0] touch_minor;
        logic signed [31:0] width_major;
        logic signed [31:0] width_minor;
        logic signed [31:0] orientation;
        logic signed [31:0] tracking_id;
        logic signed [31:0] pressure;
        logic signed [31:0] distance;
    } slot_entry_t;

    // result transaction
    typedef struct packed {
        logic signed [31:0] current_slot;
        logic [2:0]         slot_flags;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] touch_major;
        logic signed [31:0] touch_minor;
        logic signed [31:0] width_major;
        logic signed [31:0] width_minor;
        logic signed [31:0] orientation;
        logic signed [31:0] tracking_id;
        logic signed [31:0] pressure;
        logic signed [31:0] distance;
    } result_t;

    // control from the sequencer to the slot memory
    typedef struct packed {
        logic wipe;
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    // cleared slot pattern
    localparam slot_entry_t CLEAR_ENTRY = '{
        slot_flags:  3'd0,
        pos_x:       32'sd0,
        pos_y:       32'sd0,
        touch_major: 32'sd0,
        touch_minor: 32'sd0,
        width_major: 32'sd0,
        width_minor: 32'sd0,
        orientation: 32'sd0,
        tracking_id: -32'sd1,
        pressure:    32'sd0,
        distance:    32'sd0
    };

endpackage

>>> src/multitouch_slot_accumulator_top.sv
// multitouch_slot_accumulator_top: evdev multitouch slot table with apb configuration
// instantiates msa_slot_mem; depends on msa_pkg
//
//   channel   direction  handshake                   payload
//   item      in         item_valid / item_stall     msa_pkg::item_t
//   result    out        result_valid / result_stall msa_pkg::result_t
//   apb       in/out     psel penable pwrite pready  paddr pwdata prdata
//
// each transaction reads the addressed slot from the slot memory in ST_IDLE,
// then in ST_MODIFY modifies it, writes it back and loads the result register.
// the modify cycle repeats while a previous result is held by result_stall.
// reset clears the per-slot valid bits at once; no clearing pass is needed, and
// wipes (frame end if protocol_reg=0, reset op, slot_count write) clear them too.
module multitouch_slot_accumulator_top #(
    parameter int SLOTS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             item_valid,
    output logic             item_stall,
    input  msa_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output msa_pkg::result_t result
);
    import msa_pkg::*;

    localparam int          IW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [31:0] SLOTS_W = 32'(SLOTS);

    // configuration registers
    logic [4:0]  slot_count_reg;
    logic        protocol_reg;
    logic        cfg_write;
    logic        cfg_wipe;

    // sequencer state
    state_t      state_reg, state_next;
    logic [31:0] cur_slot_reg, cur_slot_next;
    logic [IW-1:0] addr_reg, addr_next;
    logic        emit_valid_reg, emit_valid_next;
    logic        mod_reg, mod_next;
    logic [9:0]  code_reg;
    logic [31:0] val_reg;
    logic        result_valid_reg, result_valid_next;
    result_t     result_reg, result_next;

    logic        accept;
    logic        accept_wipe;
    logic [31:0] active_count;
    logic [31:0] ridx_ext;
    logic        known_code;
    logic        cur_ok;
    logic        out_free;
    mem_ctl_t    mem_ctl;
    slot_entry_t rd_entry;
    slot_entry_t new_entry;

    // apply one axis event to a slot
    function automatic slot_entry_t apply_event(slot_entry_t base, logic [9:0] code,
                                                logic [31:0] val, logic proto);
        slot_entry_t e;
        logic        set_inuse;
        e = base;
        set_inuse = 1'b1;
        case (code)
            CODE_X:      e.pos_x = val;
            CODE_Y:      e.pos_y = val;
            CODE_TMAJOR: e.touch_major = val;
            CODE_TMINOR:
            begin
                e.touch_minor = val;
                e.slot_flags[FLAG_TMINOR] = 1'b1;
            end
            CODE_WMAJOR: e.width_major = val;
            CODE_WMINOR:
            begin
                e.width_minor = val;
                e.slot_flags[FLAG_WMINOR] = 1'b1;
            end
            CODE_ORIENT: e.orientation = val;
            CODE_PRESS:  e.pressure = val;
            CODE_DIST:   e.distance = val;
            CODE_TRACK:
            begin
                if (proto && val[31])
                begin
                    // negative id frees the slot but keeps its values
                    e.slot_flags[FLAG_INUSE] = 1'b0;
                    set_inuse = 1'b0;
                end
                else
                begin
                    e.tracking_id = val;
                end
            end
            default: set_inuse = 1'b0;
        endcase
        if (set_inuse)
        begin
            e.slot_flags[FLAG_INUSE] = 1'b1;
        end
        return e;
    endfunction

    // apb register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_wipe  = cfg_write && (paddr[2] == REG_SLOT_COUNT);
    assign prdata    = (paddr[2] == REG_PROTOCOL) ? {31'd0, protocol_reg}
                                                  : {27'd0, slot_count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= 5'd0;
            protocol_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_SLOT_COUNT)
            begin
                slot_count_reg <= pwdata[4:0];
            end
            else
            begin
                protocol_reg <= pwdata[0];
            end
        end
    end

    // effective slot count and read index
    assign active_count = ({27'd0, slot_count_reg} < SLOTS_W) ? {27'd0, slot_count_reg}
                                                              : SLOTS_W;
    assign ridx_ext     = {28'd0, item.read_index};

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign out_free   = !result_valid_reg || !result_stall;

    // decode of an accepted transaction: new current slot, address, modify
    always_comb
    begin
        cur_slot_next = cur_slot_reg;
        accept_wipe   = 1'b0;
        known_code    = 1'b0;
        case (item.event_code)
            CODE_X, CODE_Y, CODE_TMAJOR, CODE_TMINOR, CODE_WMAJOR, CODE_WMINOR,
            CODE_ORIENT, CODE_PRESS, CODE_DIST, CODE_TRACK: known_code = 1'b1;
            default: known_code = 1'b0;
        endcase
        unique case (item.operation)
            OP_EVENT:
            begin
                if (item.event_type == EVT_ABS)
                begin
                    if (protocol_reg)
                    begin
                        if (item.event_code == CODE_SLOT)
                        begin
                            cur_slot_next = item.event_value;
                        end
                    end
                    else if (cur_slot_reg[31])
                    begin
                        cur_slot_next = 32'd0;
                    end
                end
                else if (item.event_type == EVT_SYN && item.event_code == CODE_MT_REPORT)
                begin
                    cur_slot_next = cur_slot_reg + 32'd1;
                end
            end
            OP_FRAME_END:
            begin
                if (!protocol_reg)
                begin
                    accept_wipe   = 1'b1;
                    cur_slot_next = '1;
                end
            end
            OP_RESET:
            begin
                accept_wipe   = 1'b1;
                cur_slot_next = protocol_reg ? item.initial_slot : '1;
            end
            OP_READ: cur_slot_next = cur_slot_reg;
        endcase
        cur_ok = !cur_slot_next[31] && (cur_slot_next < active_count);
        if (item.operation == OP_READ)
        begin
            addr_next       = ridx_ext[IW-1:0];
            emit_valid_next = (ridx_ext < SLOTS_W);
            mod_next        = 1'b0;
        end
        else
        begin
            addr_next       = cur_slot_next[IW-1:0];
            emit_valid_next = cur_ok;
            mod_next        = (item.operation == OP_EVENT) && (item.event_type == EVT_ABS)
                              && cur_ok && known_code;
        end
    end

    // transaction registers, loaded on accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_slot_reg <= '1;
        end
        else if (accept)
        begin
            cur_slot_reg <= cur_slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg       <= addr_next;
            emit_valid_reg <= emit_valid_next;
            mod_reg        <= mod_next;
            code_reg       <= item.event_code;
            val_reg        <= item.event_value;
        end
    end

    // modified slot from the memory read; only axis events change it
    assign new_entry = mod_reg ? apply_event(rd_entry, code_reg, val_reg, protocol_reg)
                               : rd_entry;

    // sequencer: next state, memory control and result load
    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        mem_ctl.wipe      = cfg_wipe;
        mem_ctl.rd_en     = 1'b0;
        mem_ctl.wr_en     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mem_ctl.rd_en = 1'b1;
                    mem_ctl.wipe  = cfg_wipe || accept_wipe;
                    state_next    = ST_MODIFY;
                end
            end
            ST_MODIFY:
            begin
                if (out_free)
                begin
                    mem_ctl.wr_en     = mod_reg;
                    result_valid_next = 1'b1;
                    result_next.current_slot = cur_slot_reg;
                    if (emit_valid_reg)
                    begin
                        {result_next.slot_flags, result_next.pos_x, result_next.pos_y,
                         result_next.touch_major, result_next.touch_minor,
                         result_next.width_major, result_next.width_minor,
                         result_next.orientation, result_next.tracking_id,
                         result_next.pressure, result_next.distance} = new_entry;
                    end
                    else
                    begin
                        {result_next.slot_flags, result_next.pos_x, result_next.pos_y,
                         result_next.touch_major, result_next.touch_minor,
                         result_next.width_major, result_next.width_minor,
                         result_next.orientation, result_next.tracking_id,
                         result_next.pressure, result_next.distance} = CLEAR_ENTRY;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // slot memory
    msa_slot_mem #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_slot_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mem_ctl),
        .rd_addr  (addr_next),
        .wr_addr  (addr_reg),
        .wr_data  (new_entry),
        .rd_entry (rd_entry)
    );

endmodule

>>> src/msa_slot_mem.sv
// msa_slot_mem: slot memory with registered read and per-slot valid bits
// a slot whose valid bit is clear reads as the cleared pattern
// depends on msa_pkg
module msa_slot_mem #(
    parameter int SLOTS = 16,
    parameter int IW    = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  msa_pkg::mem_ctl_t    ctl,
    input  logic [IW-1:0]        rd_addr,
    input  logic [IW-1:0]        wr_addr,
    input  msa_pkg::slot_entry_t wr_data,
    output msa_pkg::slot_entry_t rd_entry
);
    import msa_pkg::*;

    slot_entry_t      slot_mem [SLOTS];
    slot_entry_t      rd_data_reg;
    logic [IW-1:0]    rd_addr_reg;
    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;

    // memory array: write port and registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // valid bits: wipe clears all, a write marks its slot
    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.wipe)
        begin
            valid_next = '0;
        end
        if (ctl.wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // slots never written since the last wipe read as cleared
    assign rd_entry = valid_reg[rd_addr_reg] ? rd_data_reg : CLEAR_ENTRY;

endmodule
